// ===== rtl/core/masg_pkg.sv =====
// Shared types, reset values and tables for the altitude setpoint generator.
package masg_pkg;

    localparam logic [13:0] CLIMB_RESET     = 14'd3000;
    localparam logic [13:0] DESCENT_RESET   = 14'd1000;
    localparam logic [12:0] YAW_RATE_RESET  = 13'd3491;
    localparam logic [13:0] HOLD_THR_RESET  = 14'd200;

    localparam logic [3:0] REG_CLIMB    = 4'd0;
    localparam logic [3:0] REG_DESCENT  = 4'd1;
    localparam logic [3:0] REG_YAW_RATE = 4'd2;
    localparam logic [3:0] REG_HOLD_THR = 4'd3;

    localparam int CORDIC_STEPS = 16;
    localparam int ROOT_STEPS   = 17;
    localparam int DIV_STEPS    = 17;

    typedef struct packed {
        logic       start;
        logic       rot_step;
        logic       gain;
        logic       square;
        logic       sqrt_init;
        logic       sqrt_step;
        logic       div_load_x;
        logic       div_load_y;
        logic       div_step;
        logic       load_out;
        logic [4:0] iter;
    } masg_cmd_t;

    typedef struct packed {
        logic need_norm;
    } masg_status_t;

    function automatic logic signed [33:0] atan_entry(input logic [3:0] idx);
        case (idx)
            4'd0:    atan_entry = 34'sd536870912;
            4'd1:    atan_entry = 34'sd316933406;
            4'd2:    atan_entry = 34'sd167458907;
            4'd3:    atan_entry = 34'sd85004756;
            4'd4:    atan_entry = 34'sd42667331;
            4'd5:    atan_entry = 34'sd21354465;
            4'd6:    atan_entry = 34'sd10679838;
            4'd7:    atan_entry = 34'sd5340245;
            4'd8:    atan_entry = 34'sd2670163;
            4'd9:    atan_entry = 34'sd1335087;
            4'd10:   atan_entry = 34'sd667544;
            4'd11:   atan_entry = 34'sd333772;
            4'd12:   atan_entry = 34'sd166886;
            4'd13:   atan_entry = 34'sd83443;
            4'd14:   atan_entry = 34'sd41722;
            default: atan_entry = 34'sd20861;
        endcase
    endfunction

endpackage

// ===== rtl/core/manual_altitude_setpoint_generator_core.sv =====
// Top level of the manual altitude-hold setpoint generator.
//
// Usage: one control tick is transferred on the input channel (in_valid,
// in_stall); one result is transferred on the output channel (out_valid,
// out_stall) per tick. Register writes arrive on the cfg channel (cfg_valid,
// cfg_ready, cfg_index, cfg_data); cfg_ready is always high, unknown
// indexes are dropped.
// When the thrust is already inside the unit circle, a tick runs 16 CORDIC
// steps, gain, square, check and the output load; when it is not, a 17-step
// square root and two 17-step divisions, each with its own load step, run
// between the check and the output load. An activate tick runs the same
// sequence on its sticks and takes the same time.
// A new tick is taken only in the idle state, once the previous tick has left
// the last step, since the CORDIC stage, root unit and divider are shared.
// in_stall is high while a tick is being worked on.
// The result sits in an output register, so a new tick is taken while the
// previous result still waits; when the receiver stalls, the finished tick
// waits in the last step until the output register frees.
// Reset clears the holds (no heading, no altitude), empties the output
// register and restores the register reset values.
module manual_altitude_setpoint_generator_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               mode,
    input  logic signed [15:0] stick_x,
    input  logic signed [15:0] stick_y,
    input  logic signed [15:0] stick_z_raw,
    input  logic signed [15:0] stick_z_shaped,
    input  logic signed [15:0] stick_yaw_shaped,
    input  logic signed [15:0] vehicle_yaw,
    input  logic signed [31:0] altitude_down,
    input  logic signed [15:0] vertical_speed,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [13:0] yaw_rate_setpoint,
    output logic signed [15:0] heading_setpoint,
    output logic               heading_valid,
    output logic signed [14:0] vertical_speed_setpoint,
    output logic signed [31:0] altitude_setpoint,
    output logic               altitude_valid,
    output logic signed [15:0] thrust_x,
    output logic signed [15:0] thrust_y,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [3:0]         cfg_index,
    input  logic [13:0]        cfg_data
);
    import masg_pkg::*;

    logic [13:0]  climb_reg;
    logic [13:0]  descent_reg;
    logic [12:0]  yaw_lim_reg;
    logic [13:0]  hold_thr_reg;
    masg_cmd_t    cmd;
    masg_status_t status;

    assign cfg_ready = 1'b1;

    // register file: take a transfer whenever valid, drop unknown indexes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            climb_reg    <= CLIMB_RESET;
            descent_reg  <= DESCENT_RESET;
            yaw_lim_reg  <= YAW_RATE_RESET;
            hold_thr_reg <= HOLD_THR_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_CLIMB:    climb_reg    <= cfg_data;
                REG_DESCENT:  descent_reg  <= cfg_data;
                REG_YAW_RATE: yaw_lim_reg  <= cfg_data[12:0];
                REG_HOLD_THR: hold_thr_reg <= cfg_data;
                default:      ;
            endcase
        end
    end

    masg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    masg_datapath u_dp (
        .clk                     (clk),
        .rst_n                   (rst_n),
        .cmd                     (cmd),
        .status                  (status),
        .mode                    (mode),
        .stick_x                 (stick_x),
        .stick_y                 (stick_y),
        .stick_z_raw             (stick_z_raw),
        .stick_z_shaped          (stick_z_shaped),
        .stick_yaw_shaped        (stick_yaw_shaped),
        .vehicle_yaw             (vehicle_yaw),
        .altitude_down           (altitude_down),
        .vertical_speed          (vertical_speed),
        .climb_speed_limit       (climb_reg),
        .descent_speed_limit     (descent_reg),
        .yaw_rate_limit          (yaw_lim_reg),
        .hold_speed_threshold    (hold_thr_reg),
        .yaw_rate_setpoint       (yaw_rate_setpoint),
        .heading_setpoint        (heading_setpoint),
        .heading_valid           (heading_valid),
        .vertical_speed_setpoint (vertical_speed_setpoint),
        .altitude_setpoint       (altitude_setpoint),
        .altitude_valid          (altitude_valid),
        .thrust_x                (thrust_x),
        .thrust_y                (thrust_y)
    );

endmodule

// ===== rtl/core/masg_ctrl.sv =====
// Sequencer for the setpoint generator: steps the datapath through one tick.
module masg_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    output logic                  out_valid,
    input  logic                  out_stall,
    input  masg_pkg::masg_status_t status,
    output masg_pkg::masg_cmd_t   cmd
);
    import masg_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_ROT  = 4'd1;
    localparam logic [3:0] S_GAIN = 4'd2;
    localparam logic [3:0] S_SQ   = 4'd3;
    localparam logic [3:0] S_CHK  = 4'd4;
    localparam logic [3:0] S_SQRT = 4'd5;
    localparam logic [3:0] S_DLX  = 4'd6;
    localparam logic [3:0] S_DX   = 4'd7;
    localparam logic [3:0] S_DLY  = 4'd8;
    localparam logic [3:0] S_DY   = 4'd9;
    localparam logic [3:0] S_FIN  = 4'd10;

    logic [3:0] state_reg, state_next;
    logic [4:0] cnt_reg, cnt_next;
    logic       out_valid_reg, out_valid_next;
    logic       accept;
    logic       out_free;

    assign in_stall  = (state_reg != S_IDLE);
    assign accept    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd            = '0;
        cmd.iter       = cnt_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.start  = 1'b1;
                    cnt_next   = 5'd0;
                    state_next = S_ROT;
                end
            end
            S_ROT:
            begin
                cmd.rot_step = 1'b1;
                cnt_next     = cnt_reg + 5'd1;
                if (cnt_reg == 5'(CORDIC_STEPS - 1))
                begin
                    state_next = S_GAIN;
                end
            end
            S_GAIN:
            begin
                cmd.gain   = 1'b1;
                state_next = S_SQ;
            end
            S_SQ:
            begin
                cmd.square = 1'b1;
                state_next = S_CHK;
            end
            S_CHK:
            begin
                cmd.sqrt_init = 1'b1;
                cnt_next      = 5'd0;
                state_next    = status.need_norm ? S_SQRT : S_FIN;
            end
            S_SQRT:
            begin
                cmd.sqrt_step = 1'b1;
                cnt_next      = cnt_reg + 5'd1;
                if (cnt_reg == 5'(ROOT_STEPS - 1))
                begin
                    state_next = S_DLX;
                end
            end
            S_DLX:
            begin
                cmd.div_load_x = 1'b1;
                cnt_next       = 5'd0;
                state_next     = S_DX;
            end
            S_DX:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 5'd1;
                if (cnt_reg == 5'(DIV_STEPS - 1))
                begin
                    state_next = S_DLY;
                end
            end
            S_DLY:
            begin
                cmd.div_load_y = 1'b1;
                cnt_next       = 5'd0;
                state_next     = S_DY;
            end
            S_DY:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 5'd1;
                if (cnt_reg == 5'(DIV_STEPS - 1))
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                // hold the finished result until the output register frees up
                if (out_free)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= 5'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_start_rot: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == S_ROT)
        else $error("accepted tick did not start rotation");

    a_rot_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_ROT |-> cnt_reg < 5'(CORDIC_STEPS))
        else $error("rotation step count overran");

    a_fin_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN && out_valid_reg && out_stall) |=> state_reg == S_FIN)
        else $error("result overwrote a pending output");

    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |=> (state_reg == S_IDLE && out_valid_reg))
        else $error("output load without valid");

endmodule

// ===== rtl/core/masg_datapath.sv =====
// Datapath: hold logic, CORDIC rotation, magnitude, square root and divider.
module masg_datapath (
    input  logic                        clk,
    input  logic                        rst_n,
    input  masg_pkg::masg_cmd_t         cmd,
    output masg_pkg::masg_status_t      status,
    input  logic                        mode,
    input  logic signed [15:0]          stick_x,
    input  logic signed [15:0]          stick_y,
    input  logic signed [15:0]          stick_z_raw,
    input  logic signed [15:0]          stick_z_shaped,
    input  logic signed [15:0]          stick_yaw_shaped,
    input  logic signed [15:0]          vehicle_yaw,
    input  logic signed [31:0]          altitude_down,
    input  logic signed [15:0]          vertical_speed,
    input  logic [13:0]                 climb_speed_limit,
    input  logic [13:0]                 descent_speed_limit,
    input  logic [12:0]                 yaw_rate_limit,
    input  logic [13:0]                 hold_speed_threshold,
    output logic signed [13:0]          yaw_rate_setpoint,
    output logic signed [15:0]          heading_setpoint,
    output logic                        heading_valid,
    output logic signed [14:0]          vertical_speed_setpoint,
    output logic signed [31:0]          altitude_setpoint,
    output logic                        altitude_valid,
    output logic signed [15:0]          thrust_x,
    output logic signed [15:0]          thrust_y
);
    import masg_pkg::*;

    // hold state
    logic signed [15:0] held_heading_reg;
    logic               heading_locked_reg;
    logic signed [31:0] held_alt_reg;
    logic               alt_locked_reg;

    // per-tick pending values
    logic               act_reg;
    logic signed [13:0] yaw_p_reg;
    logic signed [14:0] vz_p_reg;

    // rotation and normalization
    logic signed [26:0] x_reg, y_reg;
    logic signed [33:0] z_reg;
    logic signed [17:0] tx_reg, ty_reg;
    logic [33:0]        n_reg;
    logic               norm_reg;
    logic [33:0]        rem_reg, root_reg, bit_reg;
    logic [33:0]        drem_reg, dsh_reg;
    logic [16:0]        q_reg, qx_reg;

    // output register
    logic signed [13:0] yaw_o_reg;
    logic signed [15:0] hdg_o_reg;
    logic               hdg_v_o_reg;
    logic signed [14:0] vz_o_reg;
    logic signed [31:0] alt_o_reg;
    logic               alt_v_o_reg;
    logic signed [15:0] tx_o_reg, ty_o_reg;

    // tick front end
    logic signed [29:0] yaw_prod;
    logic signed [30:0] yaw_sum;
    logic signed [13:0] yaw_rate;
    logic [13:0]        vz_lim;
    logic signed [30:0] vz_prod;
    logic signed [31:0] vz_sum;
    logic signed [14:0] vz_val;
    logic               hlock_new;
    logic signed [15:0] hheld_new;
    logic signed [15:0] angle;
    logic               flip;
    logic signed [16:0] ang_adj;
    logic signed [26:0] x0, y0;
    logic               brake, stopped;
    logic [16:0]        vmag;

    // iterative units
    logic signed [26:0] cdx, cdy;
    logic signed [33:0] atn;
    logic signed [44:0] gx, gy;
    logic signed [35:0] sqx, sqy;
    logic [34:0]        sq_trial;
    logic               sq_ge;
    logic signed [17:0] dsel;
    logic [16:0]        dmag;
    logic               dge;
    logic signed [17:0] fx, fy;

    always_comb
    begin
        yaw_prod  = stick_yaw_shaped * $signed({1'b0, yaw_rate_limit});
        yaw_sum   = 31'(yaw_prod) + 31'sd16384;
        yaw_rate  = 14'(yaw_sum >>> 15);
        vz_lim    = (stick_z_raw > 16'sd0) ? descent_speed_limit : climb_speed_limit;
        vz_prod   = stick_z_shaped * $signed({1'b0, vz_lim});
        vz_sum    = 32'(vz_prod) + 32'sd16384;
        vz_val    = 15'(vz_sum >>> 15);

        if (yaw_rate != 14'sd0)
        begin
            hlock_new = 1'b0;
            hheld_new = held_heading_reg;
        end
        else if (!heading_locked_reg)
        begin
            hlock_new = 1'b1;
            hheld_new = vehicle_yaw;
        end
        else
        begin
            hlock_new = 1'b1;
            hheld_new = held_heading_reg;
        end
        angle   = hlock_new ? hheld_new : vehicle_yaw;
        flip    = (angle > 16'sd16384) || (angle < -16'sd16384);
        ang_adj = flip ? ((angle > 16'sd0) ? 17'(angle) - 17'sd32768
                                           : 17'(angle) + 17'sd32768)
                       : 17'(angle);
        x0      = 27'(stick_x) <<< 8;
        y0      = 27'(stick_y) <<< 8;
        if (flip)
        begin
            x0 = -x0;
            y0 = -y0;
        end

        brake   = (stick_z_shaped == 16'sd0);
        vmag    = (vertical_speed < 16'sd0) ? 17'(-18'(vertical_speed))
                                            : 17'(vertical_speed);
        stopped = (hold_speed_threshold == 14'd0) || (vmag < 17'(hold_speed_threshold));

        cdx  = y_reg >>> cmd.iter[3:0];
        cdy  = x_reg >>> cmd.iter[3:0];
        atn  = atan_entry(cmd.iter[3:0]);
        gx   = x_reg * 45'sd39797;
        gy   = y_reg * 45'sd39797;
        sqx  = tx_reg * tx_reg;
        sqy  = ty_reg * ty_reg;

        sq_trial = {1'b0, root_reg} + {1'b0, bit_reg};
        sq_ge    = {1'b0, rem_reg} >= sq_trial;

        dsel = cmd.div_load_y ? ty_reg : tx_reg;
        dmag = (dsel < 18'sd0) ? 17'(-dsel) : 17'(dsel);
        dge  = drem_reg >= dsh_reg;

        if (act_reg)
        begin
            fx = 18'sd0;
            fy = 18'sd0;
        end
        else if (norm_reg)
        begin
            fx = (tx_reg < 18'sd0) ? -$signed({1'b0, qx_reg}) : $signed({1'b0, qx_reg});
            fy = (ty_reg < 18'sd0) ? -$signed({1'b0, q_reg}) : $signed({1'b0, q_reg});
        end
        else
        begin
            fx = tx_reg;
            fy = ty_reg;
        end
    end

    assign status.need_norm = n_reg > (34'd1 << 30);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_heading_reg   <= '0;
            heading_locked_reg <= 1'b0;
            held_alt_reg       <= '0;
            alt_locked_reg     <= 1'b0;
        end
        else if (cmd.start)
        begin
            if (mode)
            begin
                heading_locked_reg <= 1'b0;
                held_alt_reg       <= altitude_down;
                alt_locked_reg     <= 1'b1;
            end
            else
            begin
                heading_locked_reg <= hlock_new;
                held_heading_reg   <= hheld_new;
                if (brake && stopped && !alt_locked_reg)
                begin
                    held_alt_reg   <= altitude_down;
                    alt_locked_reg <= 1'b1;
                end
                else if (!(alt_locked_reg && brake))
                begin
                    alt_locked_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            act_reg   <= mode;
            yaw_p_reg <= mode ? 14'sd0 : yaw_rate;
            vz_p_reg  <= mode ? 15'sd0 : vz_val;
            x_reg     <= x0;
            y_reg     <= y0;
            z_reg     <= 34'(ang_adj) <<< 16;
        end
        if (cmd.rot_step)
        begin
            if (z_reg >= 34'sd0)
            begin
                x_reg <= x_reg - cdx;
                y_reg <= y_reg + cdy;
                z_reg <= z_reg - atn;
            end
            else
            begin
                x_reg <= x_reg + cdx;
                y_reg <= y_reg - cdy;
                z_reg <= z_reg + atn;
            end
        end
        if (cmd.gain)
        begin
            tx_reg <= 18'((gx + 45'sd8388608) >>> 24);
            ty_reg <= 18'((gy + 45'sd8388608) >>> 24);
        end
        if (cmd.square)
        begin
            n_reg <= 34'(37'(sqx) + 37'(sqy));
        end
        if (cmd.sqrt_init)
        begin
            norm_reg <= status.need_norm;
            rem_reg  <= n_reg;
            root_reg <= '0;
            bit_reg  <= 34'd1 << 32;
        end
        if (cmd.sqrt_step)
        begin
            if (sq_ge)
            begin
                rem_reg  <= 34'({1'b0, rem_reg} - sq_trial);
                root_reg <= (root_reg >> 1) + bit_reg;
            end
            else
            begin
                root_reg <= root_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
        if (cmd.div_load_x || cmd.div_load_y)
        begin
            drem_reg <= {2'b00, dmag, 15'd0} + {18'd0, root_reg[16:1]};
            dsh_reg  <= {1'b0, root_reg[16:0], 16'd0};
            q_reg    <= '0;
        end
        if (cmd.div_load_y)
        begin
            qx_reg <= q_reg;
        end
        if (cmd.div_step)
        begin
            if (dge)
            begin
                drem_reg <= drem_reg - dsh_reg;
            end
            q_reg   <= {q_reg[15:0], dge};
            dsh_reg <= dsh_reg >> 1;
        end
        if (cmd.load_out)
        begin
            yaw_o_reg   <= yaw_p_reg;
            hdg_v_o_reg <= heading_locked_reg;
            hdg_o_reg   <= heading_locked_reg ? held_heading_reg : 16'sd0;
            vz_o_reg    <= vz_p_reg;
            alt_v_o_reg <= alt_locked_reg;
            alt_o_reg   <= alt_locked_reg ? held_alt_reg : 32'sd0;
            tx_o_reg    <= (fx > 18'sd32767) ? 16'sd32767 :
                           (fx < -18'sd32768) ? -16'sd32768 : 16'(fx);
            ty_o_reg    <= (fy > 18'sd32767) ? 16'sd32767 :
                           (fy < -18'sd32768) ? -16'sd32768 : 16'(fy);
        end
    end

    assign yaw_rate_setpoint       = yaw_o_reg;
    assign heading_setpoint        = hdg_o_reg;
    assign heading_valid           = hdg_v_o_reg;
    assign vertical_speed_setpoint = vz_o_reg;
    assign altitude_setpoint       = alt_o_reg;
    assign altitude_valid          = alt_v_o_reg;
    assign thrust_x                = tx_o_reg;
    assign thrust_y                = ty_o_reg;

endmodule
